// File: sv/keyed_attribute_snapshot_table_core_defines.svh
// Assertion macros for the keyed attribute snapshot table checks
`ifndef KEYED_ATTRIBUTE_SNAPSHOT_TABLE_CORE_DEFINES_SVH
`define KEYED_ATTRIBUTE_SNAPSHOT_TABLE_CORE_DEFINES_SVH

// check that b holds in the cycle after a
`define KAST_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

// check that b holds in the cycle of a
`define KAST_ASSERT_SAME(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

`endif

// File: sv/kast_pkg.sv
// Shared types and constants of the keyed attribute snapshot table
`timescale 1ns / 1ps
package kast_pkg;
  localparam int ATTR_SLOTS  = 16;
  localparam int TOTAL_SLOTS = ATTR_SLOTS + 2;
  localparam int IDX_W       = $clog2(TOTAL_SLOTS);

  localparam logic [2:0] CMD_UPDATE    = 3'd0;
  localparam logic [2:0] CMD_CLEAR     = 3'd1;
  localparam logic [2:0] CMD_COMMISSION = 3'd2;
  localparam logic [2:0] CMD_DUMP      = 3'd3;
  localparam logic [2:0] CMD_CLEAR_ALL = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NO_SPACE  = 2'd3;

  localparam logic REG_SESSION_LIMIT = 1'b0;
  localparam logic REG_COMM_TYPE     = 1'b1;

  typedef struct packed {
    logic        present;
    logic        kind;
    logic [15:0] endpoint;
    logic [31:0] cluster;
    logic [31:0] attribute;
    logic [31:0] value;
    logic [7:0]  type_code;
    logic [31:0] revision;
  } rec_t;
endpackage

// File: sv/keyed_attribute_snapshot_table_core.sv
// Top level of the keyed attribute snapshot table
// Usage:
//   Requests enter on req_valid/req_ready with cmd and the key and data fields.
//   Results leave on rsp_valid/rsp_ready, one per request, or, for a dump that
//   fits and finds records, one per record; last marks the final result of a request.
//   Registers are written on cfg_valid/cfg_ready (always ready) with cfg_index
//   and cfg_data, to be written only while the block is idle, which it does not enforce.
// Timing:
//   The slots sit in a ring of cells that rotates one slot per cycle unless a
//   due result waits on rsp_ready. The first rotation searches and counts, the
//   second writes the chosen slot and emits results; req_ready rises only when
//   the block is back in idle, so no new request is taken before then.
//   A plain result is registered at the last step of the second rotation, a dump
//   record from slot k when slot k reaches the head in it; either later under stall.
// Reset:
//   rst clears all slots and the generation counter and sets the registers to
//   their defaults; the block is ready in the next cycle.
// Stall:
//   When the receiver holds rsp_ready low with a result waiting, the ring
//   holds once the next result is due, until the waiting result is taken.
`timescale 1ns / 1ps
module keyed_attribute_snapshot_table_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [2:0]  cmd,
  input  logic [15:0] endpoint,
  input  logic [31:0] cluster,
  input  logic [31:0] attribute,
  input  logic [31:0] new_value,
  input  logic [7:0]  new_value_type,
  input  logic [7:0]  commissioning_state,
  input  logic [6:0]  capacity,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [1:0]  status,
  output logic        record_valid,
  output logic        rec_kind,
  output logic [15:0] rec_endpoint,
  output logic [31:0] rec_cluster,
  output logic [31:0] rec_attribute,
  output logic [31:0] rec_value,
  output logic [7:0]  rec_value_type,
  output logic [31:0] rec_revision,
  output logic [6:0]  record_count,
  output logic [31:0] generation,
  output logic        last
);
  import kast_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TOTAL_SLOTS - 1);

  logic [1:0]       state;
  logic [IDX_W-1:0] step;
  logic [2:0]       cmd_q;
  logic [15:0]      ep_q;
  logic [31:0]      cl_q, at_q, val_q, gen;
  logic [7:0]       vt_q, cs_q, session_limit, comm_type;
  logic [6:0]       cap_q, count, rc, emitted;
  logic             hit, free_ok, do_write, do_free, dump_emit;
  logic [IDX_W-1:0] hit_idx, free_idx, target;
  logic [1:0]       plain_status;

  rec_t cell_rec [TOTAL_SLOTS];
  rec_t head, tail_in, new_rec;
  logic clear_cells, rotate, emit_rec, emit_plain, out_free, match, in_attr;
  logic [6:0] count_next;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign head      = cell_rec[0];
  assign out_free  = !rsp_valid || rsp_ready;
  assign in_attr   = (step < IDX_W'(ATTR_SLOTS));
  assign match     = head.present && (head.endpoint == ep_q) &&
                     (head.cluster == cl_q) && (head.attribute == at_q);
  assign count_next = count + {6'd0, head.present};
  assign emit_rec   = (state == S_APPLY) && dump_emit && head.present;
  assign emit_plain = (state == S_APPLY) && !dump_emit && (step == LAST_STEP);
  assign rotate     = (state == S_SCAN) ||
                      ((state == S_APPLY) && (!(emit_rec || emit_plain) || out_free));
  assign clear_cells = (state == S_SCAN) && (step == LAST_STEP) &&
                       (cmd_q == CMD_CLEAR_ALL);

  always_comb begin
    new_rec = head;
    if (cmd_q == CMD_COMMISSION) begin
      new_rec.present    = 1'b1;
      new_rec.kind       = 1'b1;
      new_rec.value      = {24'd0, cs_q};
      new_rec.type_code  = comm_type;
      new_rec.revision   = gen;
    end else begin
      new_rec.present    = 1'b1;
      new_rec.kind       = 1'b0;
      new_rec.endpoint   = ep_q;
      new_rec.cluster    = cl_q;
      new_rec.attribute  = at_q;
      new_rec.value      = val_q;
      new_rec.type_code  = vt_q;
      new_rec.revision   = gen;
    end
    tail_in = head;
    if ((state == S_APPLY) && (step == target)) begin
      if (do_write) begin
        tail_in = new_rec;
      end else if (do_free) begin
        tail_in.present = 1'b0;
      end
    end
  end

  for (genvar i = 0; i < TOTAL_SLOTS; i++) begin : g_cell
    rec_t sin;
    if (i == TOTAL_SLOTS - 1) begin : g_tail
      assign sin = tail_in;
    end else begin : g_mid
      assign sin = cell_rec[i+1];
    end
    kast_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .clear    (clear_cells),
      .shift_en (rotate),
      .shift_in (sin),
      .rec      (cell_rec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_limit <= 8'd2;
      comm_type     <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SESSION_LIMIT: session_limit <= cfg_data;
        REG_COMM_TYPE:     comm_type     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      gen       <= '0;
      do_write  <= 1'b0;
      do_free   <= 1'b0;
      dump_emit <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state   <= S_SCAN;
            step    <= '0;
            cmd_q   <= cmd;
            ep_q    <= endpoint;
            cl_q    <= cluster;
            at_q    <= attribute;
            val_q   <= new_value;
            vt_q    <= new_value_type;
            cs_q    <= commissioning_state;
            cap_q   <= capacity;
            count   <= '0;
            hit     <= 1'b0;
            free_ok <= 1'b0;
            hit_idx <= '0;
            free_idx <= '0;
          end
        end
        S_SCAN: begin
          count <= count_next;
          if (in_attr && match && !hit) begin
            hit     <= 1'b1;
            hit_idx <= step;
          end
          if (in_attr && !head.present && !free_ok) begin
            free_ok  <= 1'b1;
            free_idx <= step;
          end
          if (step == LAST_STEP) begin
            state        <= S_APPLY;
            step         <= '0;
            emitted      <= '0;
            rc           <= '0;
            do_write     <= 1'b0;
            do_free      <= 1'b0;
            dump_emit    <= 1'b0;
            target       <= '0;
            plain_status <= ST_OK;
            case (cmd_q)
              CMD_UPDATE: begin
                if (hit || free_ok) begin
                  target   <= hit ? hit_idx : free_idx;
                  do_write <= 1'b1;
                  gen      <= gen + 32'd1;
                end else begin
                  plain_status <= ST_FULL;
                end
              end
              CMD_CLEAR: begin
                if (hit) begin
                  target  <= hit_idx;
                  do_free <= 1'b1;
                  gen     <= gen + 32'd1;
                end else begin
                  plain_status <= ST_NOT_FOUND;
                end
              end
              CMD_COMMISSION: begin
                target   <= (cs_q > session_limit) ? IDX_W'(ATTR_SLOTS + 1)
                                                   : IDX_W'(ATTR_SLOTS);
                do_write <= 1'b1;
                gen      <= gen + 32'd1;
              end
              CMD_DUMP: begin
                if (count_next > cap_q) begin
                  plain_status <= ST_NO_SPACE;
                  rc           <= count_next;
                end else if (count_next != 7'd0) begin
                  dump_emit <= 1'b1;
                  rc        <= count_next;
                end
              end
              CMD_CLEAR_ALL: gen <= '0;
              default: ;
            endcase
          end else begin
            step <= step + IDX_W'(1);
          end
        end
        S_APPLY: begin
          if (rotate) begin
            if (emit_rec) begin
              emitted <= emitted + 7'd1;
            end
            if (step == LAST_STEP) begin
              state <= S_IDLE;
            end else begin
              step <= step + IDX_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((emit_rec || emit_plain) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((emit_rec || emit_plain) && out_free) begin
      record_count <= rc;
      generation   <= gen;
      if (emit_rec) begin
        status         <= ST_OK;
        record_valid   <= 1'b1;
        rec_kind       <= head.kind;
        rec_endpoint   <= head.endpoint;
        rec_cluster    <= head.cluster;
        rec_attribute  <= head.attribute;
        rec_value      <= head.value;
        rec_value_type <= head.type_code;
        rec_revision   <= head.revision;
        last           <= ((emitted + 7'd1) == rc);
      end else begin
        status         <= plain_status;
        record_valid   <= 1'b0;
        rec_kind       <= 1'b0;
        rec_endpoint   <= '0;
        rec_cluster    <= '0;
        rec_attribute  <= '0;
        rec_value      <= '0;
        rec_value_type <= '0;
        rec_revision   <= '0;
        last           <= 1'b1;
      end
    end
  end
endmodule

// File: sv/kast_cell.sv
// One slot cell of the rotating record ring
`timescale 1ns / 1ps
module kast_cell (
  input  logic         clk,
  input  logic         rst,
  input  logic         clear,
  input  logic         shift_en,
  input  kast_pkg::rec_t shift_in,
  output kast_pkg::rec_t rec
);
  import kast_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      rec <= '0;
    end else if (shift_en) begin
      rec <= shift_in;
    end
  end
endmodule

// File: sv/kast_checker.sv
// Port level checks of the keyed attribute snapshot table and their binding
`timescale 1ns / 1ps
`include "keyed_attribute_snapshot_table_core_defines.svh"
module kast_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic        record_valid,
  input logic [6:0]  record_count,
  input logic [31:0] rec_revision,
  input logic        last
);
  import kast_pkg::*;

  `KAST_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
  `KAST_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
  `KAST_ASSERT_SAME(a_plain_last, rsp_valid && !record_valid, last && rec_revision == 32'd0)
  `KAST_ASSERT_SAME(a_err_plain, rsp_valid && status != ST_OK,
                    !record_valid && (status == ST_NO_SPACE || record_count == 7'd0))
endmodule

bind keyed_attribute_snapshot_table_core kast_checker u_kast_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_ready    (req_ready),
  .rsp_valid    (rsp_valid),
  .rsp_ready    (rsp_ready),
  .status       (status),
  .record_valid (record_valid),
  .record_count (record_count),
  .rec_revision (rec_revision),
  .last         (last)
);

// File: tb/keyed_attribute_snapshot_table_core_tb.sv
// Self-checking testbench for the keyed attribute snapshot table core
`timescale 1ns / 1ps
module keyed_attribute_snapshot_table_core_tb;
  import kast_pkg::*;

  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] endpoint;
    logic [31:0] cluster;
    logic [31:0] attribute;
    logic [31:0] new_value;
    logic [7:0]  new_value_type;
    logic [7:0]  commissioning_state;
    logic [6:0]  capacity;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        record_valid;
    logic        rec_kind;
    logic [15:0] rec_endpoint;
    logic [31:0] rec_cluster;
    logic [31:0] rec_attribute;
    logic [31:0] rec_value;
    logic [7:0]  rec_value_type;
    logic [31:0] rec_revision;
    logic [6:0]  record_count;
    logic [31:0] generation;
    logic        last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [2:0] cmd = '0;
  logic [15:0] endpoint = '0;
  logic [31:0] cluster = '0;
  logic [31:0] attribute = '0;
  logic [31:0] new_value = '0;
  logic [7:0] new_value_type = '0;
  logic [7:0] commissioning_state = '0;
  logic [6:0] capacity = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic [1:0] status;
  logic record_valid;
  logic rec_kind;
  logic [15:0] rec_endpoint;
  logic [31:0] rec_cluster;
  logic [31:0] rec_attribute;
  logic [31:0] rec_value;
  logic [7:0] rec_value_type;
  logic [31:0] rec_revision;
  logic [6:0] record_count;
  logic [31:0] generation;
  logic last;

  always #1 clk = ~clk;

  keyed_attribute_snapshot_table_core u_dut (.*);

  // table mirror
  rec_t       mirror_slot [TOTAL_SLOTS];
  logic [31:0] mirror_gen;
  logic [7:0] mirror_limit;
  logic [7:0] mirror_type;

  result_t expected_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  longint unsigned cycle_count = 0;

  request_t directed_rows[$];
  result_t  directed_known[$];
  bit       directed_has_known[$];

  function automatic result_t plain_result(logic [1:0] st, logic [6:0] cnt);
    result_t r;
    r = '0;
    r.status = st;
    r.record_count = cnt;
    r.generation = mirror_gen;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic clear_mirror();
    for (int i = 0; i < TOTAL_SLOTS; i++) mirror_slot[i] = '0;
    mirror_gen = '0;
  endtask

  function automatic int find_key(request_t q, output bit hit);
    int free_idx;
    free_idx = -1;
    hit = 0;
    for (int i = 0; i < ATTR_SLOTS; i++) begin
      if (!mirror_slot[i].present) begin
        if (free_idx < 0) free_idx = i;
      end else if (mirror_slot[i].endpoint == q.endpoint &&
                   mirror_slot[i].cluster == q.cluster &&
                   mirror_slot[i].attribute == q.attribute) begin
        hit = 1;
        return i;
      end
    end
    return free_idx;
  endfunction

  task automatic predict_table(request_t q);
    bit hit;
    int s;
    int n;
    int unsigned cap;
    int unsigned cnt;
    result_t r;
    cap = (q.capacity > 64) ? 64 : q.capacity;
    case (q.cmd)
      CMD_UPDATE: begin
        s = find_key(q, hit);
        if (s < 0) begin
          expected_results.push_back(plain_result(ST_FULL, 7'd0));
        end else begin
          mirror_gen++;
          mirror_slot[s] = '{1'b1, 1'b0, q.endpoint, q.cluster, q.attribute,
                             q.new_value, q.new_value_type, mirror_gen};
          expected_results.push_back(plain_result(ST_OK, 7'd0));
        end
      end
      CMD_CLEAR: begin
        s = find_key(q, hit);
        if (s < 0 || !hit) begin
          expected_results.push_back(plain_result(ST_NOT_FOUND, 7'd0));
        end else begin
          mirror_slot[s].present = 1'b0;
          mirror_gen++;
          expected_results.push_back(plain_result(ST_OK, 7'd0));
        end
      end
      CMD_COMMISSION: begin
        s = ATTR_SLOTS + ((q.commissioning_state > mirror_limit) ? 1 : 0);
        mirror_gen++;
        mirror_slot[s].present = 1'b1;
        mirror_slot[s].kind = 1'b1;
        mirror_slot[s].revision = mirror_gen;
        mirror_slot[s].value = {24'd0, q.commissioning_state};
        mirror_slot[s].type_code = mirror_type;
        expected_results.push_back(plain_result(ST_OK, 7'd0));
      end
      CMD_DUMP: begin
        cnt = 0;
        for (int i = 0; i < TOTAL_SLOTS; i++) cnt += mirror_slot[i].present;
        if (cnt > cap) begin
          expected_results.push_back(plain_result(ST_NO_SPACE, cnt[6:0]));
        end else if (cnt == 0) begin
          expected_results.push_back(plain_result(ST_OK, 7'd0));
        end else begin
          n = 0;
          for (int i = 0; i < TOTAL_SLOTS; i++) begin
            if (mirror_slot[i].present) begin
              n++;
              r = '0;
              r.status = ST_OK;
              r.record_valid = 1'b1;
              r.rec_kind = mirror_slot[i].kind;
              r.rec_endpoint = mirror_slot[i].endpoint;
              r.rec_cluster = mirror_slot[i].cluster;
              r.rec_attribute = mirror_slot[i].attribute;
              r.rec_value = mirror_slot[i].value;
              r.rec_value_type = mirror_slot[i].type_code;
              r.rec_revision = mirror_slot[i].revision;
              r.record_count = cnt[6:0];
              r.generation = mirror_gen;
              r.last = (n == cnt);
              expected_results.push_back(r);
            end
          end
        end
      end
      CMD_CLEAR_ALL: begin
        clear_mirror();
        expected_results.push_back(plain_result(ST_OK, 7'd0));
      end
      default: expected_results.push_back(plain_result(ST_OK, 7'd0));
    endcase
  endtask

  task automatic send_request(request_t q);
    if (($urandom_range(99, 0)) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while (($urandom_range(99, 0)) < send_idle_pct) @(posedge clk);
    end
    req_valid <= 1'b1;
    {cmd, endpoint, cluster, attribute, new_value, new_value_type,
     commissioning_state, capacity} <= q;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_table(q);
  endtask

  task automatic write_register(logic idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_SESSION_LIMIT) mirror_limit = data;
    else mirror_type = data;
    @(posedge clk);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic request_t random_request(logic [15:0] ep_pool);
    request_t q;
    int unsigned pick;
    q = '0;
    pick = $urandom_range(99, 0);
    if (pick < 45) q.cmd = CMD_UPDATE;
    else if (pick < 70) q.cmd = CMD_CLEAR;
    else if (pick < 80) q.cmd = CMD_COMMISSION;
    else if (pick < 92) q.cmd = CMD_DUMP;
    else if (pick < 95) q.cmd = CMD_CLEAR_ALL;
    else q.cmd = 3'($urandom_range(7, 5));
    if ($urandom_range(9, 0) < 8) begin
      q.endpoint = 16'($urandom_range(3, 0)) ^ ep_pool;
      q.cluster = 32'($urandom_range(3, 0));
      q.attribute = 32'($urandom_range(5, 0));
    end else begin
      q.endpoint = 16'($urandom);
      q.cluster = $urandom;
      q.attribute = $urandom;
    end
    q.new_value = $urandom;
    q.new_value_type = 8'($urandom);
    q.commissioning_state = 8'($urandom);
    q.capacity = ($urandom_range(3, 0) == 0) ? 7'($urandom) : 7'($urandom_range(64, 10));
    return q;
  endfunction

  task automatic add_row(request_t q, bit known, result_t r);
    directed_rows.push_back(q);
    directed_has_known.push_back(known);
    directed_known.push_back(r);
  endtask

  task automatic build_directed();
    request_t q;
    result_t r;
    q = '0; q.cmd = CMD_DUMP; q.capacity = 7'd64;
    r = '0; r.last = 1'b1;
    add_row(q, 1, r);
    q = '0; q.cmd = CMD_CLEAR; q.endpoint = '1; q.cluster = '1; q.attribute = '1;
    r = '0; r.status = ST_NOT_FOUND; r.last = 1'b1;
    add_row(q, 1, r);
    q = '0; q.cmd = CMD_UPDATE; q.endpoint = '1; q.cluster = '1; q.attribute = '1;
    q.new_value = '1; q.new_value_type = '1;
    r = '0; r.generation = 32'd1; r.last = 1'b1;
    add_row(q, 1, r);
    for (int i = 0; i < 16; i++) begin
      q = '0; q.cmd = CMD_UPDATE; q.endpoint = 16'(i); q.cluster = 32'(i);
      q.new_value = 32'h5a5a0000 + i; q.new_value_type = 8'(i);
      add_row(q, 0, r);
    end
    q = '0; q.cmd = CMD_COMMISSION; q.commissioning_state = 8'd2;
    add_row(q, 0, r);
    q.commissioning_state = 8'hff;
    add_row(q, 0, r);
    q = '0; q.cmd = CMD_DUMP; q.capacity = 7'd1;
    add_row(q, 0, r);
    q.capacity = 7'h7f;
    add_row(q, 0, r);
    q = '0; q.cmd = 3'd7;
    add_row(q, 0, r);
    q = '0; q.cmd = CMD_CLEAR_ALL;
    r = '0; r.last = 1'b1;
    add_row(q, 1, r);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst) rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result status=%0d", $time, status);
        mismatch_count++;
      end else begin
        result_t want;
        result_t got;
        want = expected_results.pop_front();
        got = '{status, record_valid, rec_kind, rec_endpoint, rec_cluster,
                rec_attribute, rec_value, rec_value_type, rec_revision,
                record_count, generation, last};
        if (got !== want) begin
          $display("%0t result mismatch expected %h actual %h", $time, want, got);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    request_t q;
    logic [15:0] ep_pool;
    mirror_limit = 8'd2;
    mirror_type = 8'd0;
    clear_mirror();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    build_directed();
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i]);
      if (directed_has_known[i]) expected_results[expected_results.size() - 1] =
        directed_known[i];
    end
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 77 : 0;
      recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 15 : 0;
      write_register(REG_SESSION_LIMIT, (phase == 0) ? 8'd0 : (phase == 1) ? 8'hff :
                     8'($urandom));
      write_register(REG_COMM_TYPE, (phase == 0) ? 8'hff : (phase == 1) ? 8'd0 :
                     8'($urandom));
      ep_pool = 16'($urandom);
      for (int k = 0; k < 115; k++) begin
        q = random_request(ep_pool);
        send_request(q);
        if (k == 60) drain_results();
      end
      drain_results();
    end

    if (mismatch_count != 0 || expected_results.size() != 0) begin
      $display("Verification failed");
    end else begin
      $display("Verification passed");
    end
    $finish;
  end
endmodule
